### rtl/core/mtrd_pkg.sv
package mtrd_pkg;

    localparam int unsigned WORDS      = 624;
    localparam int unsigned OFFSET     = 397;
    localparam int unsigned IDX_W      = 10;
    localparam logic [31:0] SEED_DEFAULT = 32'd4357;
    localparam logic [31:0] SEED_MULT    = 32'd69069;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;
    localparam logic [IDX_W-1:0] IDX_NEVER = IDX_W'(WORDS + 1);
    localparam logic [IDX_W-1:0] IDX_EMPTY = IDX_W'(WORDS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;     // capture the input beat
        logic fill_start;    // word 0 of a fill, from the input seed or the default seed
        logic fill_default;  // fill uses the default seed
        logic fill_step;     // write one more fill word
        logic twist_start;
        logic twist_rd;      // read phase of one twist word
        logic twist_wr;      // write phase of one twist word
        logic draw_rd;       // read the word at the read index
        logic draw_temper;
        logic div_start;
        logic set_result;    // publish the result register
        logic zero_result;
    } mtrd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_reseed;
        logic bound_zero;
        logic idx_never;
        logic idx_empty;
        logic fill_done;
        logic twist_done;
        logic div_done;
    } mtrd_stat_t;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

### rtl/core/mersenne_twister_ranged_draw.sv
// A draw from a live table reads and tempers a word, then reduces it with the
// bit-serial remainder unit; a zero bound gives zero; a reseed fills the whole table.
// A draw that exhausts the table adds a twist, one word at a time,
// limited by the single table read port; the first draw with a nonzero bound also fills the table.
// One item at a time: a new beat is taken only when idle and the last result is gone or leaves now.
// Reset clears the index to never seeded and the seed to 1.
module mersenne_twister_ranged_draw
    import mtrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] seed,
    input  logic [31:0] bound,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] number,
    output logic [31:0] current_seed
);

    mtrd_cmd_t  cmd;
    mtrd_stat_t stat;

    mtrd_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mtrd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_operation (operation),
        .in_seed      (seed),
        .in_bound     (bound),
        .stat         (stat),
        .number       (number),
        .current_seed (current_seed)
    );

endmodule

### rtl/core/mtrd_divider.sv
// Restoring remainder unit: one quotient bit per cycle.
module mtrd_divider
    import mtrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);

    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    // One shift and trial subtract per cycle.
    always_comb
    begin
        shifted   = {rem_reg[31:0], quo_reg[31]};
        diff      = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = diff[32] ? shifted : diff;
            quo_next = {quo_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            dvs_reg <= divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[31:0];

endmodule

### rtl/core/mtrd_datapath.sv
// Table memory, index and seed registers, fill and twist address logic.
module mtrd_datapath
    import mtrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mtrd_cmd_t   cmd,
    input  logic        in_operation,
    input  logic [31:0] in_seed,
    input  logic [31:0] in_bound,
    output mtrd_stat_t  stat,
    output logic [31:0] number,
    output logic [31:0] current_seed
);

    logic [31:0] table_mem [WORDS];
    logic        op_reg;
    logic [31:0] seed_in_reg;
    logic [31:0] bound_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [31:0] seed_reg;
    logic [31:0] prev_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_nx;
    logic [IDX_W-1:0] pos_far;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0] rd_data_reg;
    logic [31:0] cur_reg;
    logic [31:0] nxt_reg;
    logic [31:0] tw_word;
    logic [31:0] y_word;
    logic [31:0] temp_reg;
    logic [1:0]  ph_reg;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0] wr_data;
    logic [31:0] num_reg;
    logic        div_done;
    logic [31:0] div_rem;
    logic        fill_mul_ok;

    assign fill_mul_ok = 1'b1;

    // Neighbor addresses with wrap.
    always_comb
    begin
        pos_nx  = (pos_reg == IDX_W'(WORDS - 1)) ? '0 : pos_reg + 1'b1;
        pos_far = (pos_reg >= IDX_W'(WORDS - OFFSET)) ? pos_reg - IDX_W'(WORDS - OFFSET)
                                                       : pos_reg + IDX_W'(OFFSET);
    end

    // Twist read phases: 0 reads next, 1 reads far; the read data is registered.
    always_comb
    begin
        rd_addr = pos_nx;
        if (cmd.draw_rd)
            rd_addr = idx_reg;
        else if (cmd.twist_rd && ph_reg == 2'd1)
            rd_addr = pos_far;
        else if (cmd.twist_start)
            rd_addr = '0;
    end

    assign y_word  = (cur_reg & 32'h80000000) | (nxt_reg & 32'h7fffffff);
    assign tw_word = rd_data_reg ^ (y_word >> 1) ^ (y_word[0] ? TWIST_MATRIX : 32'd0);

    // Write port: fill words or twisted words.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = prev_reg;
        if (cmd.fill_start)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = cmd.fill_default ? SEED_DEFAULT : seed_in_reg;
        end
        else if (cmd.fill_step)
        begin
            wr_en   = fill_mul_ok;
            wr_data = prev_reg * SEED_MULT;
        end
        else if (cmd.twist_wr)
        begin
            wr_en   = 1'b1;
            wr_data = tw_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= wr_data;
        rd_data_reg <= table_mem[rd_addr];
    end

    // Sequencing registers for fill, twist and draw.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= IDX_NEVER;
            seed_reg <= 32'd1;
            pos_reg  <= '0;
            ph_reg   <= '0;
            num_reg  <= '0;
        end
        else
        begin
            if (cmd.fill_start)
            begin
                seed_reg <= wr_data;
                pos_reg  <= IDX_W'(1);
                idx_reg  <= IDX_EMPTY;
            end
            else if (cmd.fill_step)
            begin
                pos_reg  <= pos_nx;
            end
            if (cmd.twist_start)
            begin
                pos_reg <= '0;
                ph_reg  <= 2'd0;
            end
            else if (cmd.twist_rd)
            begin
                // Phase 0 issues next read; phase 1 captures next, issues far.
                if (ph_reg == 2'd0)
                begin
                    ph_reg <= 2'd1;
                end
                else
                begin
                    ph_reg  <= 2'd2;
                end
            end
            else if (cmd.twist_wr)
            begin
                ph_reg  <= 2'd0;
                pos_reg <= pos_nx;
                if (pos_reg == IDX_W'(WORDS - 1))
                    idx_reg <= '0;
            end
            if (cmd.draw_temper)
            begin
                idx_reg  <= idx_reg + 1'b1;
            end
            if (cmd.set_result)
                num_reg <= cmd.zero_result ? 32'd0 : div_rem;
        end
    end

    // Data registers: previous fill word, running twist words, tempered word.
    // Word 0 is loaded into cur_reg during the priming read of the sweep.
    always_ff @(posedge clk)
    begin
        if (cmd.fill_start || cmd.fill_step)
            prev_reg <= wr_data;
        if (cmd.twist_rd && ph_reg == 2'd1)
            nxt_reg <= rd_data_reg;
        if (cmd.twist_wr)
            cur_reg <= nxt_reg;
        else if (cmd.twist_rd && ph_reg == 2'd0 && pos_reg == '0)
            cur_reg <= rd_data_reg;
        if (cmd.draw_temper)
            temp_reg <= temper(rd_data_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg      <= in_operation;
            seed_in_reg <= in_seed;
            bound_reg   <= in_bound;
        end
    end

    mtrd_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (temp_reg),
        .divisor   (bound_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        stat.op_reseed  = op_reg;
        stat.bound_zero = (bound_reg == 32'd0);
        stat.idx_never  = (idx_reg == IDX_NEVER);
        stat.idx_empty  = (idx_reg >= IDX_EMPTY);
        stat.fill_done  = (pos_reg == IDX_W'(WORDS - 1));
        stat.twist_done = (pos_reg == IDX_W'(WORDS - 1));
        stat.div_done   = div_done;
    end

    assign number       = num_reg;
    assign current_seed = seed_reg;

endmodule

### rtl/core/mtrd_control.sv
// Sequencer: decode, fill, twist, draw, divide, result handshake.
module mtrd_control
    import mtrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  mtrd_stat_t stat,
    output mtrd_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_FILL, S_TW_INIT, S_TW_PRIME, S_TW_RD0, S_TW_RD1,
        S_TW_WR, S_DRAW_RD, S_DRAW_WAIT, S_TEMPER, S_DIV, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   dflt_reg, dflt_next;
    logic   ov_reg, ov_next;

    // A new beat is taken only once the held result is gone or leaves now.
    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        dflt_next  = dflt_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
                else if (in_valid && ov_reg && out_ready)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.op_reseed)
                begin
                    cmd.fill_start = 1'b1;
                    dflt_next      = 1'b0;
                    state_next     = S_FILL;
                end
                else if (stat.bound_zero)
                begin
                    cmd.set_result  = 1'b1;
                    cmd.zero_result = 1'b1;
                    state_next      = S_OUT;
                end
                else if (stat.idx_never)
                begin
                    cmd.fill_start   = 1'b1;
                    cmd.fill_default = 1'b1;
                    dflt_next        = 1'b1;
                    state_next       = S_FILL;
                end
                else if (stat.idx_empty)
                begin
                    state_next = S_TW_INIT;
                end
                else
                begin
                    state_next = S_DRAW_RD;
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (stat.fill_done)
                begin
                    if (dflt_reg)
                        state_next = S_TW_INIT;
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_TW_INIT:
            begin
                // Read word 0 to seed the running current word.
                cmd.twist_start = 1'b1;
                state_next      = S_TW_PRIME;
            end
            S_TW_PRIME:
            begin
                cmd.twist_rd = 1'b1;
                state_next   = S_TW_RD1;
            end
            S_TW_RD0:
            begin
                cmd.twist_rd = 1'b1;
                state_next   = S_TW_RD1;
            end
            S_TW_RD1:
            begin
                cmd.twist_rd = 1'b1;
                state_next   = S_TW_WR;
            end
            S_TW_WR:
            begin
                cmd.twist_wr = 1'b1;
                state_next   = stat.twist_done ? S_DRAW_RD : S_TW_RD0;
            end
            S_DRAW_RD:
            begin
                cmd.draw_rd = 1'b1;
                state_next  = S_DRAW_WAIT;
            end
            S_DRAW_WAIT:
            begin
                // Hold the read address so the word stays in the read register.
                cmd.draw_rd = 1'b1;
                state_next  = S_TEMPER;
            end
            S_TEMPER:
            begin
                cmd.draw_temper = 1'b1;
                state_next      = S_DIV;
            end
            S_DIV:
            begin
                if (!dflt_reg)
                    cmd.div_start = 1'b1;
                dflt_next = 1'b1;
                if (stat.div_done)
                begin
                    cmd.set_result = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                dflt_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_TEMPER)
            dflt_next = 1'b0;
        if (state_reg == S_FILL && stat.fill_done && !dflt_reg)
        begin
            cmd.set_result  = 1'b1;
            cmd.zero_result = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dflt_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dflt_reg  <= dflt_next;
            ov_reg    <= ov_next;
        end
    end

endmodule
